>>> hw/rtl/vtna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtna_pkg
// Shared widths, angle constants and the arctangent table of the norm and
// angle unit.
// ----------------------------------------------------------------------------
package vtna_pkg;

	localparam int ANGLE_STAGES_DEF  = 20;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int VEC_W     = 32;
	localparam int NORM_W    = 32;
	localparam int SQ_W      = 64;
	localparam int THETA_W   = 25;
	localparam int PHI_W     = 24;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 1;

	localparam int GUARD_BITS = 8;
	localparam int ANGLE_W    = 26;

	localparam int unsigned DEG90  = 5898240;
	localparam int unsigned DEG180 = 11796480;
	localparam int unsigned DEG270 = 17694720;
	localparam int unsigned DEG360 = 23592960;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLE_LIMIT = 1'b0,
		CFG_NORM_FLOOR = 1'b1
	} cfg_index_t;

	// Arctangent of 2^-i in 1/65536 degree, rounded.
	localparam logic [21:0] ATAN_DEG_TAB [32] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0,
		22'd0,       22'd0,       22'd0,      22'd0,
		22'd0,       22'd0,       22'd0,      22'd0
	};

endpackage
`default_nettype wire

>>> hw/rtl/vtna_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtna_sqrt_cell
// One cell of the square root chain: decides one root bit and passes the
// remainder, the partial root and a side word to the next cell.
// ----------------------------------------------------------------------------
module vtna_sqrt_cell #(
	parameter int VW  = 64,
	parameter int RW  = 32,
	parameter int K   = 0,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  logic [VW-1:0]  val_i,
	input  logic [RW-1:0]  root_i,
	input  logic [SBW-1:0] sb_i,
	output logic           valid_o,
	output logic [VW-1:0]  val_o,
	output logic [RW-1:0]  root_o,
	output logic [SBW-1:0] sb_o
);

	logic [VW-1:0]  trial;
	logic           take;
	logic           valid_q;
	logic [VW-1:0]  val_q;
	logic [RW-1:0]  root_q;
	logic [SBW-1:0] sb_q;

	// The partial root only has bits above K, so the increment of its square
	// is a plain OR of two shifted terms.
	assign trial = (VW'(root_i) << (K + 1)) | (VW'(1) << (2 * K));
	assign take  = val_i >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q  <= take ? val_i - trial : val_i;
			root_q <= take ? (root_i | (RW'(1) << K)) : root_i;
			sb_q   <= sb_i;
		end
	end

	assign valid_o = valid_q;
	assign val_o   = val_q;
	assign root_o  = root_q;
	assign sb_o    = sb_q;

endmodule
`default_nettype wire

>>> hw/rtl/vtna_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtna_div_cell
// One cell of the restoring divider chain: one quotient bit per lane against
// a shared divisor.
// ----------------------------------------------------------------------------
module vtna_div_cell #(
	parameter int LANES = 1,
	parameter int DW    = 32,
	parameter int QW    = 17,
	parameter bit SHIFT = 1'b1,
	parameter int SBW   = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_i,
	input  logic [LANES-1:0][DW:0]      rem_i,
	input  logic [LANES-1:0][QW-1:0]    quo_i,
	input  logic [DW-1:0]               div_i,
	input  logic [SBW-1:0]              sb_i,
	output logic                        valid_o,
	output logic [LANES-1:0][DW:0]      rem_o,
	output logic [LANES-1:0][QW-1:0]    quo_o,
	output logic [DW-1:0]               div_o,
	output logic [SBW-1:0]              sb_o
);

	logic [LANES-1:0][DW:0]   sh;
	logic [LANES-1:0][DW:0]   rem_n;
	logic [LANES-1:0][QW-1:0] quo_n;
	logic [LANES-1:0]         ge;
	logic                     valid_q;
	logic [LANES-1:0][DW:0]   rem_q;
	logic [LANES-1:0][QW-1:0] quo_q;
	logic [DW-1:0]            div_q;
	logic [SBW-1:0]           sb_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sh[l]    = SHIFT ? {rem_i[l][DW-1:0], 1'b0} : rem_i[l];
			ge[l]    = sh[l] >= {1'b0, div_i};
			rem_n[l] = ge[l] ? sh[l] - {1'b0, div_i} : sh[l];
			quo_n[l] = {quo_i[l][QW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			div_q <= div_i;
			sb_q  <= sb_i;
		end
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign quo_o   = quo_q;
	assign div_o   = div_q;
	assign sb_o    = sb_q;

endmodule
`default_nettype wire

>>> hw/rtl/vtna_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtna_cordic_cell
// One vectoring-mode CORDIC rotation with a fixed shift per cell, applied to
// each lane.
// ----------------------------------------------------------------------------
module vtna_cordic_cell #(
	parameter int LANES = 2,
	parameter int CW    = 27,
	parameter int ZW    = 26,
	parameter int I     = 0,
	parameter int SBW   = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid_i,
	input  logic [LANES-1:0][CW-1:0] x_i,
	input  logic [LANES-1:0][CW-1:0] y_i,
	input  logic [LANES-1:0][ZW-1:0] z_i,
	input  logic [SBW-1:0]           sb_i,
	output logic                     valid_o,
	output logic [LANES-1:0][CW-1:0] x_o,
	output logic [LANES-1:0][CW-1:0] y_o,
	output logic [LANES-1:0][ZW-1:0] z_o,
	output logic [SBW-1:0]           sb_o
);

	logic [ZW-1:0]            ang;
	logic [LANES-1:0][CW-1:0] x_n;
	logic [LANES-1:0][CW-1:0] y_n;
	logic [LANES-1:0][ZW-1:0] z_n;
	logic                     valid_q;
	logic [LANES-1:0][CW-1:0] x_q;
	logic [LANES-1:0][CW-1:0] y_q;
	logic [LANES-1:0][ZW-1:0] z_q;
	logic [SBW-1:0]           sb_q;

	assign ang = ZW'(vtna_pkg::ATAN_DEG_TAB[I]);

	always_comb begin : p_rot
		logic signed [CW-1:0] xc;
		logic signed [CW-1:0] yc;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		for (int l = 0; l < LANES; l++) begin
			xc = $signed(x_i[l]);
			yc = $signed(y_i[l]);
			xs = xc >>> I;
			ys = yc >>> I;
			if (yc > 0) begin
				x_n[l] = xc + ys;
				y_n[l] = yc - xs;
				z_n[l] = z_i[l] + ang;
			end else begin
				x_n[l] = xc - ys;
				y_n[l] = yc + xs;
				z_n[l] = z_i[l] - ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q  <= x_n;
			y_q  <= y_n;
			z_q  <= z_n;
			sb_q <= sb_i;
		end
	end

	assign valid_o = valid_q;
	assign x_o     = x_q;
	assign y_o     = y_q;
	assign z_o     = z_q;
	assign sb_o    = sb_q;

endmodule
`default_nettype wire

>>> hw/rtl/vector_to_norm_and_angles_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_to_norm_and_angles_unit
// Norm and two spherical angles of a signed Q16.16 3-D vector.
// ----------------------------------------------------------------------------
// The unit takes one vector word per clock while the output is not stalled,
// and returns one result word per vector, in order. The chained cells set
// the depth: 32 cells for the norm root, FRACTION_BITS+1 for the unit
// vector divide, two root chains of FRACTION_BITS+1 cells, FRACTION_BITS for
// the second divide and ANGLE_STAGES CORDIC cells, with pipeline registers
// between them. The whole chain moves forward whenever the output register
// is empty or being read, so a stalled output holds every stage in place.
// There is no clearing pass after reset. Configuration writes must only
// happen while the unit is idle.
module vector_to_norm_and_angles_unit #(
	parameter int ANGLE_STAGES  = vtna_pkg::ANGLE_STAGES_DEF,
	parameter int FRACTION_BITS = vtna_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [vtna_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vtna_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [vtna_pkg::VEC_W-1:0]   vec_x,
	input  logic signed [vtna_pkg::VEC_W-1:0]   vec_y,
	input  logic signed [vtna_pkg::VEC_W-1:0]   vec_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vtna_pkg::NORM_W-1:0]         norm_out,
	output logic [vtna_pkg::THETA_W-1:0]        theta_out,
	output logic [vtna_pkg::PHI_W-1:0]          phi_out
);

	localparam int VW   = vtna_pkg::VEC_W;
	localparam int NW   = vtna_pkg::NORM_W;
	localparam int SQW  = vtna_pkg::SQ_W;
	localparam int TW   = vtna_pkg::THETA_W;
	localparam int PHW  = vtna_pkg::PHI_W;
	localparam int F    = FRACTION_BITS;
	localparam int U    = F + 1;
	localparam int U2   = 2 * U;
	localparam int CW   = U + vtna_pkg::GUARD_BITS + 2;
	localparam int ZW   = vtna_pkg::ANGLE_W;
	localparam int PW   = F + vtna_pkg::CFG_W + 1;
	localparam logic [U-1:0]  ONE    = U'(1) << F;
	localparam logic [U2-1:0] ONE_SQ = U2'(1) << (2 * F);

	localparam int SB1_W  = 3 + 2 * VW;
	localparam int SBD1_W = NW + 4;
	localparam int SBQ2_W = NW + 2 * U + 3;
	localparam int SBD2_W = NW + 2 * U + 5;
	localparam int SBQ3_W = NW + 3 * U + 4;
	localparam int SBC_W  = NW + 3;

	localparam int LANE_THETA = 0;
	localparam int LANE_PHI   = 1;

	// ------------------------------------------------------------------
	// Configuration and flow control
	// ------------------------------------------------------------------
	logic [vtna_pkg::CFG_W-1:0] pole_lim_q;
	logic [vtna_pkg::CFG_W-1:0] norm_floor_q;
	logic                       en;
	logic                       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_lim_q   <= vtna_pkg::CFG_W'(1);
			norm_floor_q <= vtna_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				vtna_pkg::CFG_POLE_LIMIT: pole_lim_q   <= cfg_data;
				vtna_pkg::CFG_NORM_FLOOR: norm_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ------------------------------------------------------------------
	// Magnitudes and squares
	// ------------------------------------------------------------------
	logic [VW-1:0]  xm, ym, zm;
	logic [SQW-1:0] xsq, ysq, zsq;
	logic           v_s1, xneg_s1, yneg_s1, zneg_s1;
	logic [VW-1:0]  ym_s1, zm_s1;
	logic [SQW-1:0] xsq_s1, ysq_s1, zsq_s1;
	logic           v_s2, xneg_s2, yneg_s2, zneg_s2;
	logic [VW-1:0]  ym_s2, zm_s2;
	logic [SQW-1:0] sum_s2;

	assign xm  = vec_x[VW-1] ? VW'(-vec_x) : VW'(vec_x);
	assign ym  = vec_y[VW-1] ? VW'(-vec_y) : VW'(vec_y);
	assign zm  = vec_z[VW-1] ? VW'(-vec_z) : VW'(vec_z);
	assign xsq = xm * xm;
	assign ysq = ym * ym;
	assign zsq = zm * zm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xneg_s1 <= vec_x[VW-1];
			yneg_s1 <= vec_y[VW-1];
			zneg_s1 <= vec_z[VW-1];
			ym_s1   <= ym;
			zm_s1   <= zm;
			xsq_s1  <= xsq;
			ysq_s1  <= ysq;
			zsq_s1  <= zsq;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			zneg_s2 <= zneg_s1;
			ym_s2   <= ym_s1;
			zm_s2   <= zm_s1;
			sum_s2  <= xsq_s1 + ysq_s1 + zsq_s1;
		end
	end

	// ------------------------------------------------------------------
	// Norm root chain
	// ------------------------------------------------------------------
	logic             r1_v    [0:NW];
	logic [SQW-1:0]   r1_val  [0:NW];
	logic [NW-1:0]    r1_root [0:NW];
	logic [SB1_W-1:0] r1_sb   [0:NW];

	assign r1_v[0]    = v_s2;
	assign r1_val[0]  = sum_s2;
	assign r1_root[0] = '0;
	assign r1_sb[0]   = {xneg_s2, yneg_s2, zneg_s2, ym_s2, zm_s2};

	for (genvar j = 0; j < NW; j++) begin : g_root1
		vtna_sqrt_cell #(.VW(SQW), .RW(NW), .K(NW - 1 - j), .SBW(SB1_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(r1_v[j]), .val_i(r1_val[j]), .root_i(r1_root[j]), .sb_i(r1_sb[j]),
			.valid_o(r1_v[j+1]), .val_o(r1_val[j+1]), .root_o(r1_root[j+1]),
			.sb_o(r1_sb[j+1])
		);
	end

	logic          r1_xneg, r1_yneg, r1_zneg;
	logic [VW-1:0] r1_ym, r1_zm;
	logic          v_s3, uz_s3, xneg_s3, yneg_s3, zneg_s3;
	logic [NW-1:0] norm_s3;
	logic [VW-1:0] ym_s3, zm_s3;

	assign {r1_xneg, r1_yneg, r1_zneg, r1_ym, r1_zm} = r1_sb[NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= r1_v[NW];
		end
	end

	// A tiny or zero norm swaps the vector for unit z further down.
	always_ff @(posedge clk) begin
		if (en) begin
			norm_s3 <= r1_root[NW];
			uz_s3   <= (r1_root[NW] == '0) || (r1_root[NW] < NW'(norm_floor_q));
			xneg_s3 <= r1_xneg;
			yneg_s3 <= r1_yneg;
			zneg_s3 <= r1_zneg;
			ym_s3   <= r1_ym;
			zm_s3   <= r1_zm;
		end
	end

	// ------------------------------------------------------------------
	// Unit vector divide: y and z magnitudes over the norm
	// ------------------------------------------------------------------
	logic                   d1_v   [0:U];
	logic [1:0][NW:0]       d1_rem [0:U];
	logic [1:0][U-1:0]      d1_quo [0:U];
	logic [NW-1:0]          d1_div [0:U];
	logic [SBD1_W-1:0]      d1_sb  [0:U];

	assign d1_v[0]   = v_s3;
	assign d1_rem[0] = {{1'b0, zm_s3}, {1'b0, ym_s3}};
	assign d1_quo[0] = '0;
	assign d1_div[0] = norm_s3;
	assign d1_sb[0]  = {norm_s3, uz_s3, xneg_s3, yneg_s3, zneg_s3};

	// The magnitudes never exceed the norm, so the first cell takes the
	// integer bit without a shift.
	for (genvar j = 0; j < U; j++) begin : g_div1
		vtna_div_cell #(
			.LANES(2), .DW(NW), .QW(U), .SHIFT(j != 0), .SBW(SBD1_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(d1_v[j]), .rem_i(d1_rem[j]), .quo_i(d1_quo[j]),
			.div_i(d1_div[j]), .sb_i(d1_sb[j]),
			.valid_o(d1_v[j+1]), .rem_o(d1_rem[j+1]), .quo_o(d1_quo[j+1]),
			.div_o(d1_div[j+1]), .sb_o(d1_sb[j+1])
		);
	end

	logic [NW-1:0] d1_norm;
	logic          d1_uz, d1_xneg, d1_yneg, d1_zneg;
	logic [U-1:0]  d1_sint, d1_nz;

	assign {d1_norm, d1_uz, d1_xneg, d1_yneg, d1_zneg} = d1_sb[U];
	assign d1_sint = d1_quo[U][0];
	assign d1_nz   = d1_quo[U][1];

	logic          v_s4, sint_neg_s4, nz_neg_s4, x_neg_s4;
	logic [NW-1:0] norm_s4;
	logic [U-1:0]  sint_m_s4, nz_m_s4;
	logic          v_s5, sint_neg_s5, nz_neg_s5, x_neg_s5;
	logic [NW-1:0] norm_s5;
	logic [U-1:0]  sint_m_s5, nz_m_s5;
	logic [U2-1:0] ssq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= d1_v[U];
			v_s5 <= v_s4;
		end
	end

	// sint is the negated y of the unit vector; zero carries no sign.
	always_ff @(posedge clk) begin
		if (en) begin
			norm_s4     <= d1_norm;
			sint_m_s4   <= d1_uz ? '0 : d1_sint;
			sint_neg_s4 <= !d1_uz && !d1_yneg && (d1_sint != '0);
			nz_m_s4     <= d1_uz ? ONE : d1_nz;
			nz_neg_s4   <= !d1_uz && d1_zneg;
			x_neg_s4    <= !d1_uz && d1_xneg;
			norm_s5     <= norm_s4;
			sint_m_s5   <= sint_m_s4;
			sint_neg_s5 <= sint_neg_s4;
			nz_m_s5     <= nz_m_s4;
			nz_neg_s5   <= nz_neg_s4;
			x_neg_s5    <= x_neg_s4;
			ssq_s5      <= sint_m_s4 * sint_m_s4;
		end
	end

	// ------------------------------------------------------------------
	// Cosine root chain
	// ------------------------------------------------------------------
	logic              r2_v    [0:U];
	logic [U2-1:0]     r2_val  [0:U];
	logic [U-1:0]      r2_root [0:U];
	logic [SBQ2_W-1:0] r2_sb   [0:U];

	assign r2_v[0]    = v_s5;
	assign r2_val[0]  = ONE_SQ - ssq_s5;
	assign r2_root[0] = '0;
	assign r2_sb[0]   = {norm_s5, sint_m_s5, sint_neg_s5, nz_m_s5, nz_neg_s5, x_neg_s5};

	for (genvar j = 0; j < U; j++) begin : g_root2
		vtna_sqrt_cell #(.VW(U2), .RW(U), .K(U - 1 - j), .SBW(SBQ2_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(r2_v[j]), .val_i(r2_val[j]), .root_i(r2_root[j]), .sb_i(r2_sb[j]),
			.valid_o(r2_v[j+1]), .val_o(r2_val[j+1]), .root_o(r2_root[j+1]),
			.sb_o(r2_sb[j+1])
		);
	end

	logic [NW-1:0] r2_norm;
	logic [U-1:0]  r2_sint, r2_nz, r2_cost;
	logic          r2_sint_neg, r2_nz_neg, r2_x_neg;

	assign {r2_norm, r2_sint, r2_sint_neg, r2_nz, r2_nz_neg, r2_x_neg} = r2_sb[U];
	assign r2_cost = r2_root[U];

	logic          v_s6, sint_neg_s6, x_neg_s6, cp_neg_s6, pole_s6, big_s6;
	logic [NW-1:0] norm_s6;
	logic [U-1:0]  sint_m_s6, nz_m_s6, cost_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= r2_v[U];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s6     <= r2_norm;
			sint_m_s6   <= r2_sint;
			sint_neg_s6 <= r2_sint_neg;
			nz_m_s6     <= r2_nz;
			cost_s6     <= r2_cost;
			x_neg_s6    <= r2_x_neg;
			cp_neg_s6   <= r2_nz_neg != r2_x_neg;
			pole_s6     <= (r2_cost == '0) ||
				((PW'(r2_cost) << 16) < (PW'(pole_lim_q) << F));
			big_s6      <= r2_nz >= r2_cost;
		end
	end

	// ------------------------------------------------------------------
	// Phi cosine divide: nz over cost, clamped to one
	// ------------------------------------------------------------------
	logic                 d2_v   [0:F];
	logic [0:0][U:0]      d2_rem [0:F];
	logic [0:0][F-1:0]    d2_quo [0:F];
	logic [U-1:0]         d2_div [0:F];
	logic [SBD2_W-1:0]    d2_sb  [0:F];

	assign d2_v[0]   = v_s6;
	assign d2_rem[0] = big_s6 ? '0 : {1'b0, nz_m_s6};
	assign d2_quo[0] = '0;
	assign d2_div[0] = cost_s6;
	assign d2_sb[0]  = {norm_s6, sint_m_s6, sint_neg_s6, cost_s6, x_neg_s6, cp_neg_s6,
		pole_s6, big_s6};

	for (genvar j = 0; j < F; j++) begin : g_div2
		vtna_div_cell #(
			.LANES(1), .DW(U), .QW(F), .SHIFT(1'b1), .SBW(SBD2_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(d2_v[j]), .rem_i(d2_rem[j]), .quo_i(d2_quo[j]),
			.div_i(d2_div[j]), .sb_i(d2_sb[j]),
			.valid_o(d2_v[j+1]), .rem_o(d2_rem[j+1]), .quo_o(d2_quo[j+1]),
			.div_o(d2_div[j+1]), .sb_o(d2_sb[j+1])
		);
	end

	logic [NW-1:0] d2_norm;
	logic [U-1:0]  d2_sint, d2_cost;
	logic          d2_sint_neg, d2_x_neg, d2_cp_neg, d2_pole, d2_big;

	assign {d2_norm, d2_sint, d2_sint_neg, d2_cost, d2_x_neg, d2_cp_neg, d2_pole,
		d2_big} = d2_sb[F];

	logic          v_s7, sint_neg_s7, x_neg_s7, cp_neg_s7, pole_s7;
	logic [NW-1:0] norm_s7;
	logic [U-1:0]  sint_m_s7, cost_s7, cp_m_s7;
	logic          v_s8, sint_neg_s8, x_neg_s8, cp_neg_s8, pole_s8;
	logic [NW-1:0] norm_s8;
	logic [U-1:0]  sint_m_s8, cost_s8, cp_m_s8;
	logic [U2-1:0] cp2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s7 <= d2_v[F];
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s7     <= d2_norm;
			sint_m_s7   <= d2_sint;
			sint_neg_s7 <= d2_sint_neg;
			cost_s7     <= d2_cost;
			x_neg_s7    <= d2_x_neg;
			cp_neg_s7   <= d2_cp_neg;
			pole_s7     <= d2_pole;
			cp_m_s7     <= d2_big ? ONE : {1'b0, d2_quo[F][0]};
			norm_s8     <= norm_s7;
			sint_m_s8   <= sint_m_s7;
			sint_neg_s8 <= sint_neg_s7;
			cost_s8     <= cost_s7;
			x_neg_s8    <= x_neg_s7;
			cp_neg_s8   <= cp_neg_s7;
			pole_s8     <= pole_s7;
			cp_m_s8     <= cp_m_s7;
			cp2_s8      <= cp_m_s7 * cp_m_s7;
		end
	end

	// ------------------------------------------------------------------
	// Phi sine root chain
	// ------------------------------------------------------------------
	logic              r3_v    [0:U];
	logic [U2-1:0]     r3_val  [0:U];
	logic [U-1:0]      r3_root [0:U];
	logic [SBQ3_W-1:0] r3_sb   [0:U];

	assign r3_v[0]    = v_s8;
	assign r3_val[0]  = ONE_SQ - cp2_s8;
	assign r3_root[0] = '0;
	assign r3_sb[0]   = {norm_s8, sint_m_s8, sint_neg_s8, cost_s8, x_neg_s8, pole_s8,
		cp_m_s8, cp_neg_s8};

	for (genvar j = 0; j < U; j++) begin : g_root3
		vtna_sqrt_cell #(.VW(U2), .RW(U), .K(U - 1 - j), .SBW(SBQ3_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(r3_v[j]), .val_i(r3_val[j]), .root_i(r3_root[j]), .sb_i(r3_sb[j]),
			.valid_o(r3_v[j+1]), .val_o(r3_val[j+1]), .root_o(r3_root[j+1]),
			.sb_o(r3_sb[j+1])
		);
	end

	logic [NW-1:0] r3_norm;
	logic [U-1:0]  r3_sint, r3_cost, r3_cp, r3_sp;
	logic          r3_sint_neg, r3_x_neg, r3_pole, r3_cp_neg;
	logic          th_pre, ph_pre;

	assign {r3_norm, r3_sint, r3_sint_neg, r3_cost, r3_x_neg, r3_pole, r3_cp,
		r3_cp_neg} = r3_sb[U];
	assign r3_sp = r3_root[U];

	// A negative cosine starts the rotation from 90 degrees with the roles of
	// the two coordinates swapped.
	assign th_pre = r3_x_neg && (r3_cost != '0);
	assign ph_pre = r3_cp_neg && (r3_cp != '0);

	logic                 v_s9;
	logic [1:0][CW-1:0]   x_s9, y_s9;
	logic [1:0][ZW-1:0]   z_s9;
	logic [SBC_W-1:0]     sb_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= r3_v[U];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s9[LANE_THETA] <= CW'(th_pre ? r3_sint : r3_cost) << vtna_pkg::GUARD_BITS;
			y_s9[LANE_THETA] <= CW'(th_pre ? r3_cost : r3_sint) << vtna_pkg::GUARD_BITS;
			z_s9[LANE_THETA] <= th_pre ? ZW'(vtna_pkg::DEG90) : '0;
			x_s9[LANE_PHI]   <= CW'(ph_pre ? r3_sp : r3_cp) << vtna_pkg::GUARD_BITS;
			y_s9[LANE_PHI]   <= CW'(ph_pre ? r3_cp : r3_sp) << vtna_pkg::GUARD_BITS;
			z_s9[LANE_PHI]   <= ph_pre ? ZW'(vtna_pkg::DEG90) : '0;
			sb_s9            <= {r3_norm, r3_sint_neg, (r3_sint != '0) && !r3_sint_neg,
				r3_pole};
		end
	end

	// ------------------------------------------------------------------
	// CORDIC chain, theta and phi side by side
	// ------------------------------------------------------------------
	logic               c_v  [0:ANGLE_STAGES];
	logic [1:0][CW-1:0] c_x  [0:ANGLE_STAGES];
	logic [1:0][CW-1:0] c_y  [0:ANGLE_STAGES];
	logic [1:0][ZW-1:0] c_z  [0:ANGLE_STAGES];
	logic [SBC_W-1:0]   c_sb [0:ANGLE_STAGES];

	assign c_v[0]  = v_s9;
	assign c_x[0]  = x_s9;
	assign c_y[0]  = y_s9;
	assign c_z[0]  = z_s9;
	assign c_sb[0] = sb_s9;

	for (genvar j = 0; j < ANGLE_STAGES; j++) begin : g_cordic
		vtna_cordic_cell #(.LANES(2), .CW(CW), .ZW(ZW), .I(j), .SBW(SBC_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(c_v[j]), .x_i(c_x[j]), .y_i(c_y[j]), .z_i(c_z[j]), .sb_i(c_sb[j]),
			.valid_o(c_v[j+1]), .x_o(c_x[j+1]), .y_o(c_y[j+1]), .z_o(c_z[j+1]),
			.sb_o(c_sb[j+1])
		);
	end

	// ------------------------------------------------------------------
	// Clamp, pole handling and output register
	// ------------------------------------------------------------------
	logic [NW-1:0]  c_norm;
	logic           c_sint_neg, c_sint_pos, c_pole;
	logic [TW-1:0]  th_c, theta_n;
	logic [PHW-1:0] ph_c, phi_n;
	logic [NW-1:0]  norm_q;
	logic [TW-1:0]  theta_q;
	logic [PHW-1:0] phi_q;

	assign {c_norm, c_sint_neg, c_sint_pos, c_pole} = c_sb[ANGLE_STAGES];

	always_comb begin : p_clamp
		logic signed [ZW-1:0] zt;
		logic signed [ZW-1:0] zp;
		zt = $signed(c_z[ANGLE_STAGES][LANE_THETA]);
		zp = $signed(c_z[ANGLE_STAGES][LANE_PHI]);
		if (zt < 0) begin
			th_c = '0;
		end else if (zt > $signed(ZW'(vtna_pkg::DEG180))) begin
			th_c = TW'(vtna_pkg::DEG180);
		end else begin
			th_c = TW'(zt);
		end
		if (zp < 0) begin
			ph_c = '0;
		end else if (zp > $signed(ZW'(vtna_pkg::DEG180))) begin
			ph_c = PHW'(vtna_pkg::DEG180);
		end else begin
			ph_c = PHW'(zp);
		end
		if (c_pole) begin
			theta_n = c_sint_pos ? TW'(vtna_pkg::DEG90) : TW'(vtna_pkg::DEG270);
			phi_n   = '0;
		end else begin
			theta_n = c_sint_neg ? TW'(vtna_pkg::DEG360) - th_c : th_c;
			phi_n   = ph_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c_v[ANGLE_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_q  <= c_norm;
			theta_q <= theta_n;
			phi_q   <= phi_n;
		end
	end

	assign out_valid = out_valid_q;
	assign norm_out  = norm_q;
	assign theta_out = theta_q;
	assign phi_out   = phi_q;

endmodule
`default_nettype wire

>>> hw/rtl/vtna_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtna_checker
// Port-level checks of the norm and angle unit, bound to its top level.
// ----------------------------------------------------------------------------
module vtna_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [vtna_pkg::NORM_W-1:0]  norm_out,
	input logic [vtna_pkg::THETA_W-1:0] theta_out,
	input logic [vtna_pkg::PHI_W-1:0]   phi_out
);

	// With the output register free, the input side must never stall.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

	a_ready_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while output word is taken");

	a_theta_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> theta_out <= vtna_pkg::THETA_W'(vtna_pkg::DEG360))
		else $error("theta beyond 360 degrees");

	a_phi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phi_out <= vtna_pkg::PHI_W'(vtna_pkg::DEG180))
		else $error("phi beyond 180 degrees");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(norm_out) &&
			$stable(theta_out) && $stable(phi_out))
		else $error("stalled output word changed");

	// in_valid is part of the bound port set; it has no check of its own.
	logic unused_in_valid;
	assign unused_in_valid = in_valid;

endmodule

bind vector_to_norm_and_angles_unit vtna_checker u_vtna_checker (.*);
`default_nettype wire

>>> dv/vtna_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtna_scoreboard
// Watches both word channels of the norm and angle unit, predicts each result
// from the accepted vector and the current register values, and compares.
// ----------------------------------------------------------------------------
module vtna_scoreboard (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [vtna_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vtna_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [vtna_pkg::VEC_W-1:0]   vec_x,
	input  logic signed [vtna_pkg::VEC_W-1:0]   vec_y,
	input  logic signed [vtna_pkg::VEC_W-1:0]   vec_z,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [vtna_pkg::NORM_W-1:0]         norm_out,
	input  logic [vtna_pkg::THETA_W-1:0]        theta_out,
	input  logic [vtna_pkg::PHI_W-1:0]          phi_out,
	output int                                  fail_count,
	output int                                  pending_count,
	output int                                  result_count
);

	typedef struct packed {
		logic [vtna_pkg::NORM_W-1:0]  norm;
		logic [vtna_pkg::THETA_W-1:0] theta;
		logic [vtna_pkg::PHI_W-1:0]   phi;
	} angles_t;

	localparam longint ONE = 64'd1 << vtna_pkg::FRACTION_BITS_DEF;

	angles_t                        expected_q[$];
	logic [vtna_pkg::CFG_W-1:0]     pole_limit;
	logic [vtna_pkg::CFG_W-1:0]     floor_norm;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Vectoring CORDIC on (c, s); arithmetic shifts floor like the hardware.
	function automatic longint arc_cosine(longint c, longint s);
		longint x, y, z, xs, ys;
		if (c < 0) begin
			x = s; y = -c; z = longint'(vtna_pkg::DEG90);
		end else begin
			x = c; y = s; z = 0;
		end
		x = x * (64'sd1 <<< vtna_pkg::GUARD_BITS);
		y = y * (64'sd1 <<< vtna_pkg::GUARD_BITS);
		for (int i = 0; i < vtna_pkg::ANGLE_STAGES_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += longint'(vtna_pkg::ATAN_DEG_TAB[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(vtna_pkg::ATAN_DEG_TAB[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(vtna_pkg::DEG180)) z = longint'(vtna_pkg::DEG180);
		return z;
	endfunction

	function automatic angles_t predict_angles(logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [31:0] vz);
		longint unsigned xm, ym, zm, nrm, sm, nzm, cst, cpm;
		logic sneg, nzneg, xneg;
		longint sint, theta, phi, cs, cp;
		angles_t r;
		xm = vx[31] ? 64'h1_0000_0000 - {32'd0, vx} : {32'd0, vx};
		ym = vy[31] ? 64'h1_0000_0000 - {32'd0, vy} : {32'd0, vy};
		zm = vz[31] ? 64'h1_0000_0000 - {32'd0, vz} : {32'd0, vz};
		nrm = int_sqrt(xm * xm + ym * ym + zm * zm);
		if (nrm == 0 || nrm < floor_norm) begin
			sm = 0; sneg = 0; nzm = ONE; nzneg = 0; xneg = 0;
		end else begin
			sm = (ym << vtna_pkg::FRACTION_BITS_DEF) / nrm;
			nzm = (zm << vtna_pkg::FRACTION_BITS_DEF) / nrm;
			if (sm > ONE) sm = ONE;
			if (nzm > ONE) nzm = ONE;
			sneg = !vy[31];
			nzneg = vz[31];
			xneg = vx[31];
		end
		if (sm == 0) sneg = 0;
		sint = sneg ? -longint'(sm) : longint'(sm);
		cst = int_sqrt(ONE * ONE - sm * sm);
		if (cst == 0 || cst < pole_limit) begin
			theta = (sint > 0) ? longint'(vtna_pkg::DEG90) : longint'(vtna_pkg::DEG270);
			phi = 0;
		end else begin
			cs = xneg ? -longint'(cst) : longint'(cst);
			cpm = (nzm << vtna_pkg::FRACTION_BITS_DEF) / cst;
			if (cpm > ONE) cpm = ONE;
			cp = (nzneg != xneg) ? -longint'(cpm) : longint'(cpm);
			theta = arc_cosine(cs, longint'(sm));
			phi = arc_cosine(cp, longint'(int_sqrt(ONE * ONE - cpm * cpm)));
			if (sint < 0) theta = longint'(vtna_pkg::DEG360) - theta;
		end
		r.norm = (nrm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nrm[31:0];
		r.theta = theta[vtna_pkg::THETA_W-1:0];
		r.phi = phi[vtna_pkg::PHI_W-1:0];
		return r;
	endfunction

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		angles_t want;
		if (!arst_n) begin
			pole_limit <= 1;
			floor_norm <= 1;
			fail_count <= 0;
			result_count <= 0;
			expected_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (vtna_pkg::cfg_index_t'(cfg_index))
					vtna_pkg::CFG_POLE_LIMIT: pole_limit <= cfg_data;
					vtna_pkg::CFG_NORM_FLOOR: floor_norm <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_angles(vec_x, vec_y, vec_z));
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result word with nothing expected", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want.norm !== norm_out || want.theta !== theta_out
							|| want.phi !== phi_out) begin
						if (fail_count < 10)
							$display("%0t: mismatch norm %h/%h theta %0d/%0d phi %0d/%0d",
								$realtime, want.norm, norm_out, want.theta, theta_out,
								want.phi, phi_out);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> dv/vector_to_norm_and_angles_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_norm_and_angles_unit_tb
// Drives directed and random vectors through the norm and angle unit under
// several register settings and idle patterns; a checker compares results.
// ----------------------------------------------------------------------------
module vector_to_norm_and_angles_unit_tb;

	localparam int LATENCY   = 129;
	localparam int MAX_CYCLE = 1000000;

	logic                               clk = 0;
	logic                               arst_n = 0;
	logic                               cfg_wr_en = 0;
	logic [vtna_pkg::CFG_IDX_W-1:0]     cfg_index = vtna_pkg::CFG_POLE_LIMIT;
	logic [vtna_pkg::CFG_W-1:0]         cfg_data = 0;
	logic                               in_valid = 0;
	logic                               in_ready;
	logic signed [31:0]                 vec_x = 0, vec_y = 0, vec_z = 0;
	logic                               out_valid;
	logic                               out_ready = 0;
	logic [vtna_pkg::NORM_W-1:0]        norm_out;
	logic [vtna_pkg::THETA_W-1:0]       theta_out;
	logic [vtna_pkg::PHI_W-1:0]         phi_out;
	int                                 fail_count, pending_count, result_count;
	int                                 send_idle_pct, recv_idle_pct;
	int                                 cycle_count = 0;
	int                                 vectors_sent = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	vector_to_norm_and_angles_unit u_dut (.*);

	vtna_scoreboard u_check (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// The enable drops after each write so that back to back
	// writes never assign it twice in one time step.
	task automatic write_reg(vtna_pkg::cfg_index_t idx, logic [vtna_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		vectors_sent++;
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Mostly moderate magnitudes, with occasional full-range and tiny words.
	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(131071)) - 65536;
			2: return 0;
			default: return $signed($urandom) >>> $urandom_range(12);
		endcase
	endfunction

	task automatic directed_set;
		send_vector(0, 0, 0);
		send_vector(1, 0, 0);
		send_vector(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_vector(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_vector(0, 32'sh10000, 0);
		send_vector(0, -32'sh10000, 0);
		send_vector(32'sh10000, 0, 0);
		send_vector(-32'sh10000, 0, 0);
		send_vector(0, 0, -32'sh10000);
		send_vector(-32'sh10000, 32'sh8000, 32'sh10000);
		send_vector(32'sh10000, -32'sh10000, -32'sh10000);
		send_vector(-1, -1, -1);
		send_vector(32'shFFFF, 32'sh5555, 32'shAAAA);
		send_vector(-5, 3, 0);
		send_vector(32'sh80000000, 0, 32'sh7FFFFFFF);
	endtask

	initial begin
		send_idle_pct = 29;
		recv_idle_pct = 84;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_set();
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(vtna_pkg::CFG_POLE_LIMIT, 0);
					write_reg(vtna_pkg::CFG_NORM_FLOOR, 0);
				end
				1: begin
					write_reg(vtna_pkg::CFG_POLE_LIMIT, 17'h10000);
					write_reg(vtna_pkg::CFG_NORM_FLOOR, 17'h10000);
				end
				2: begin
					write_reg(vtna_pkg::CFG_POLE_LIMIT, 17'h1FFFF);
					write_reg(vtna_pkg::CFG_NORM_FLOOR, 17'h1FFFF);
				end
				default: begin
					write_reg(vtna_pkg::CFG_POLE_LIMIT,
						vtna_pkg::CFG_W'($urandom_range(4000)));
					write_reg(vtna_pkg::CFG_NORM_FLOOR,
						vtna_pkg::CFG_W'($urandom_range(65536)));
				end
			endcase
			if (ph == 2) begin
				send_idle_pct = 84;
				recv_idle_pct = 29;
			end
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph < 2) directed_set();
			for (int n = 0; n < 245; n++)
				send_vector(rand_comp(), rand_comp(), rand_comp());
			drain();
		end
		$display("Sent %0d vectors, checked %0d results over six register settings.",
			vectors_sent, result_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
